/* hw/rtl/qnl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qnl_pkg: shared types and constants for the quaternion nlerp pipeline
// Beat formats, internal widths and the side data that travels down the pipe.
// ----------------------------------------------------------------------------
package qnl_pkg;

  localparam int unsigned CompW     = 16;
  localparam int unsigned WeightW   = 17;
  localparam int unsigned ProdW     = 34;
  localparam int unsigned AbsW      = 32;
  localparam int unsigned MagW      = 31;
  localparam int unsigned SqW       = 62;
  localparam int unsigned DotW      = 63;
  localparam int unsigned RootW     = 64;
  localparam int unsigned LenW      = 32;
  localparam int unsigned NumW      = 45;
  localparam int unsigned RemW      = 47;
  localparam int unsigned QuotW     = 15;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps  = 15;
  localparam int unsigned FracQ14   = 14;

  localparam logic [WeightW-1:0] WeightOne = 17'h1_0000;
  localparam logic [QuotW-1:0]   UnitQuot  = 15'h4000;
  localparam logic [CompW-1:0]   UnitComp  = 16'h4000;
  localparam logic [AbsW-1:0]    HalveAbove = 32'h4000_0000;
  localparam logic [LenW-1:0]    MinLen    = 32'h2000_0000;

  typedef struct packed {
    logic signed [CompW-1:0] a_x;
    logic signed [CompW-1:0] a_y;
    logic signed [CompW-1:0] a_z;
    logic signed [CompW-1:0] a_w;
    logic signed [CompW-1:0] b_x;
    logic signed [CompW-1:0] b_y;
    logic signed [CompW-1:0] b_z;
    logic signed [CompW-1:0] b_w;
    logic [WeightW-1:0]      blend_weight;
  } qnl_in_t;

  typedef struct packed {
    logic signed [CompW-1:0] out_x;
    logic signed [CompW-1:0] out_y;
    logic signed [CompW-1:0] out_z;
    logic signed [CompW-1:0] out_w;
    logic                    degenerate;
  } qnl_out_t;

  typedef struct packed {
    logic                      degen;
    logic [3:0]                neg;
    logic [3:0][MagW-1:0]      mag;
  } qnl_side_t;

endpackage

/* hw/rtl/qnl_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qnl_front: blend, scale and dot product
// Eight register stages: weighted products, magnitude, maximum, shift
// amount, scaling, squares and a two-level sum tree.
// ----------------------------------------------------------------------------
module qnl_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  qnl_pkg::qnl_in_t   in_i,
  output logic               valid_o,
  output qnl_pkg::qnl_side_t side_o,
  output logic [qnl_pkg::DotW-1:0] dot_o
);
  import qnl_pkg::*;

  logic [8:1] v_q;

  logic [WeightW-1:0] tc, wa;
  logic signed [CompW-1:0] a_c [4];
  logic signed [CompW-1:0] b_c [4];

  logic signed [ProdW-1:0] pa_d [4], pa_q [4], pb_d [4], pb_q [4];
  logic [AbsW-1:0] mag2_d [4], mag2_q [4], mag3_q [4], mag4_q [4];
  logic [3:0] neg2_d, neg2_q, neg3_q, neg4_q, neg5_q, neg6_q, neg7_q, neg8_q;
  logic [AbsW-1:0] mx_d, mx3_q;
  logic big_d, big4_q, zero_d, zero4_q;
  logic degen5_q, degen6_q, degen7_q, degen8_q;
  logic [4:0] msb, shamt_d, shamt4_q;
  logic [MagW-1:0] mag5_d [4], mag5_q [4], mag6_q [4], mag7_q [4], mag8_q [4];
  logic [SqW-1:0] sq_d [4], sq_q [4];
  logic [DotW-1:0] s01_d, s23_d, s01_q, s23_q, dot_d, dot_q;

  always_comb begin
    tc = (in_i.blend_weight > WeightOne) ? WeightOne : in_i.blend_weight;
    wa = WeightOne - tc;
    a_c[0] = in_i.a_x; a_c[1] = in_i.a_y; a_c[2] = in_i.a_z; a_c[3] = in_i.a_w;
    b_c[0] = in_i.b_x; b_c[1] = in_i.b_y; b_c[2] = in_i.b_z; b_c[3] = in_i.b_w;
    for (int i = 0; i < 4; i++) begin
      pa_d[i] = a_c[i] * $signed({1'b0, wa});
      pb_d[i] = b_c[i] * $signed({1'b0, tc});
    end
  end

  always_comb begin
    logic signed [ProdW-1:0] q, av;
    for (int i = 0; i < 4; i++) begin
      q = pa_q[i] + pb_q[i];
      neg2_d[i] = q[ProdW-1];
      av = q[ProdW-1] ? -q : q;
      mag2_d[i] = av[AbsW-1:0];
    end
  end

  always_comb begin
    logic [AbsW-1:0] m01, m23;
    m01 = (mag2_q[0] > mag2_q[1]) ? mag2_q[0] : mag2_q[1];
    m23 = (mag2_q[2] > mag2_q[3]) ? mag2_q[2] : mag2_q[3];
    mx_d = (m01 > m23) ? m01 : m23;
  end

  // Shift brings the largest magnitude up into [2^29, 2^30]; anything above
  // 2^30 is halved with rounding instead.
  always_comb begin
    msb = 5'd0;
    for (int i = 0; i < 30; i++) begin
      if (mx3_q[i]) begin
        msb = 5'(i);
      end
    end
    big_d   = mx3_q > HalveAbove;
    zero_d  = (mx3_q == '0);
    shamt_d = (mx3_q[AbsW-1:29] == '0) ? 5'd29 - msb : 5'd0;
  end

  always_comb begin
    logic [AbsW:0] inc;
    logic [AbsW-1:0] shl;
    for (int i = 0; i < 4; i++) begin
      inc = {1'b0, mag4_q[i]} + 33'd1;
      shl = mag4_q[i] << shamt4_q;
      mag5_d[i] = big4_q ? inc[MagW:1] : shl[MagW-1:0];
      sq_d[i] = mag5_q[i] * mag5_q[i];
    end
    s01_d = {1'b0, sq_q[0]} + {1'b0, sq_q[1]};
    s23_d = {1'b0, sq_q[2]} + {1'b0, sq_q[3]};
    dot_d = s01_q + s23_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[7:1], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q     <= pa_d;
    pb_q     <= pb_d;
    mag2_q   <= mag2_d;
    neg2_q   <= neg2_d;
    mag3_q   <= mag2_q;
    neg3_q   <= neg2_q;
    mx3_q    <= mx_d;
    mag4_q   <= mag3_q;
    neg4_q   <= neg3_q;
    big4_q   <= big_d;
    zero4_q  <= zero_d;
    shamt4_q <= shamt_d;
    mag5_q   <= mag5_d;
    neg5_q   <= neg4_q;
    degen5_q <= zero4_q;
    sq_q     <= sq_d;
    mag6_q   <= mag5_q;
    neg6_q   <= neg5_q;
    degen6_q <= degen5_q;
    s01_q    <= s01_d;
    s23_q    <= s23_d;
    mag7_q   <= mag6_q;
    neg7_q   <= neg6_q;
    degen7_q <= degen6_q;
    dot_q    <= dot_d;
    mag8_q   <= mag7_q;
    neg8_q   <= neg7_q;
    degen8_q <= degen7_q;
  end

  always_comb begin
    valid_o      = v_q[8];
    dot_o        = dot_q;
    side_o.degen = degen8_q;
    side_o.neg   = neg8_q;
    for (int i = 0; i < 4; i++) begin
      side_o.mag[i] = mag8_q[i];
    end
  end

endmodule

/* hw/rtl/qnl_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qnl_sqrt: pipelined integer square root
// One restoring step per stage over 32 stages; the side data rides along.
// ----------------------------------------------------------------------------
module qnl_sqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [qnl_pkg::DotW-1:0] dot_i,
  input  qnl_pkg::qnl_side_t side_i,
  output logic               valid_o,
  output logic [qnl_pkg::LenW-1:0] len_o,
  output qnl_pkg::qnl_side_t side_o
);
  import qnl_pkg::*;

  logic [RootW-1:0] rem_q  [1:SqrtSteps];
  logic [RootW-1:0] res_q  [1:SqrtSteps];
  qnl_side_t        side_q [1:SqrtSteps];
  logic             v_q    [1:SqrtSteps];

  for (genvar j = 0; j < SqrtSteps; j++) begin : g_step
    localparam logic [RootW-1:0] StepBit = RootW'(1) << (62 - 2 * j);
    logic [RootW-1:0] rem_c, res_c, trial, rem_n, res_n;
    qnl_side_t side_c;
    logic v_c;

    if (j == 0) begin : g_first
      assign rem_c  = RootW'(dot_i);
      assign res_c  = '0;
      assign side_c = side_i;
      assign v_c    = valid_i;
    end else begin : g_next
      assign rem_c  = rem_q[j];
      assign res_c  = res_q[j];
      assign side_c = side_q[j];
      assign v_c    = v_q[j];
    end

    always_comb begin
      trial = res_c + StepBit;
      if (rem_c >= trial) begin
        rem_n = rem_c - trial;
        res_n = (res_c >> 1) + StepBit;
      end else begin
        rem_n = rem_c;
        res_n = res_c >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j+1] <= 1'b0;
      end else begin
        v_q[j+1] <= v_c;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[j+1]  <= rem_n;
      res_q[j+1]  <= res_n;
      side_q[j+1] <= side_c;
    end
  end

  assign valid_o = v_q[SqrtSteps];
  assign len_o   = res_q[SqrtSteps][LenW-1:0];
  assign side_o  = side_q[SqrtSteps];

  // A non-zero blend is scaled so that its length is at least 2^29.
  a_len_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !side_o.degen |-> len_o >= MinLen)
    else $error("root below scaled floor");

endmodule

/* hw/rtl/qnl_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qnl_div: four-lane pipelined rounding divider
// Forms m*2^14 + L/2, then one restoring quotient bit per stage.
// ----------------------------------------------------------------------------
module qnl_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [qnl_pkg::LenW-1:0] len_i,
  input  qnl_pkg::qnl_side_t side_i,
  output logic               valid_o,
  output logic [3:0][qnl_pkg::QuotW-1:0] quot_o,
  output logic [3:0]         neg_o,
  output logic               degen_o
);
  import qnl_pkg::*;

  logic [DivSteps:0] v_q;
  logic [3:0][RemW-1:0]  rem_q  [0:DivSteps];
  logic [3:0][QuotW-1:0] quot_q [0:DivSteps];
  logic [LenW-1:0]       len_q  [0:DivSteps];
  logic [3:0]            neg_q  [0:DivSteps];
  logic                  degen_q [0:DivSteps];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[DivSteps-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      rem_q[0][i] <= RemW'(NumW'({side_i.mag[i], 14'd0}) + NumW'(len_i >> 1));
    end
    quot_q[0]  <= '0;
    len_q[0]   <= len_i;
    neg_q[0]   <= side_i.neg;
    degen_q[0] <= side_i.degen;
  end

  for (genvar j = 0; j < DivSteps; j++) begin : g_step
    localparam int unsigned Sh = DivSteps - 1 - j;
    logic [RemW-1:0] dsr;
    logic [3:0][RemW-1:0]  rem_n;
    logic [3:0][QuotW-1:0] quot_n;

    always_comb begin
      dsr = RemW'(len_q[j]) << Sh;
      for (int i = 0; i < 4; i++) begin
        if (rem_q[j][i] >= dsr) begin
          rem_n[i]  = rem_q[j][i] - dsr;
          quot_n[i] = quot_q[j][i] | (QuotW'(1) << Sh);
        end else begin
          rem_n[i]  = rem_q[j][i];
          quot_n[i] = quot_q[j][i];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[j+1]   <= rem_n;
      quot_q[j+1]  <= quot_n;
      len_q[j+1]   <= len_q[j];
      neg_q[j+1]   <= neg_q[j];
      degen_q[j+1] <= degen_q[j];
    end
  end

  assign valid_o = v_q[DivSteps];
  assign quot_o  = quot_q[DivSteps];
  assign neg_o   = neg_q[DivSteps];
  assign degen_o = degen_q[DivSteps];

  // Each magnitude is at most the length, so a quotient never passes one.
  a_quot_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !degen_o |-> quot_o[0] <= UnitQuot && quot_o[1] <= UnitQuot &&
                            quot_o[2] <= UnitQuot && quot_o[3] <= UnitQuot)
    else $error("quotient above one");

endmodule

/* hw/rtl/quaternion_nlerp.sv */
`timescale 1ns / 1ps
// Throughput: one beat per cycle; busy is never raised, every stage is registered.
// Latency is set by the front end, 32-stage square root, divider (load plus 15 quotient stages) and output register.
// The receiver cannot stall: each result shows for exactly one cycle with done_o.
// Reset (rst_ni low, asynchronous) clears all valid bits; data registers keep no reset.
// ----------------------------------------------------------------------------
// quaternion_nlerp: normalised linear interpolation of two quaternions
// Blend, scale, dot product, square root and per-component rounding divide; a degenerate blend gives the identity.
// ----------------------------------------------------------------------------
module quaternion_nlerp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  qnl_pkg::qnl_in_t  in_i,
  output logic              done_o,
  output qnl_pkg::qnl_out_t res_o
);
  import qnl_pkg::*;

  logic      fr_valid, sq_valid, dv_valid;
  qnl_side_t fr_side, sq_side;
  logic [DotW-1:0] fr_dot;
  logic [LenW-1:0] sq_len;
  logic [3:0][QuotW-1:0] dv_quot;
  logic [3:0] dv_neg;
  logic dv_degen;

  logic     done_q;
  qnl_out_t res_d, res_q;

  assign busy = 1'b0;

  qnl_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start & ~busy),
    .in_i    (in_i),
    .valid_o (fr_valid),
    .side_o  (fr_side),
    .dot_o   (fr_dot)
  );

  qnl_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .dot_i   (fr_dot),
    .side_i  (fr_side),
    .valid_o (sq_valid),
    .len_o   (sq_len),
    .side_o  (sq_side)
  );

  qnl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_valid),
    .len_i   (sq_len),
    .side_i  (sq_side),
    .valid_o (dv_valid),
    .quot_o  (dv_quot),
    .neg_o   (dv_neg),
    .degen_o (dv_degen)
  );

  always_comb begin
    logic [QuotW-1:0] r;
    logic [CompW-1:0] c [4];
    for (int i = 0; i < 4; i++) begin
      r = (dv_quot[i] > UnitQuot) ? UnitQuot : dv_quot[i];
      c[i] = dv_neg[i] ? -{1'b0, r} : {1'b0, r};
    end
    if (dv_degen) begin
      res_d = '{out_x: '0, out_y: '0, out_z: '0, out_w: UnitComp, degenerate: 1'b1};
    end else begin
      res_d = '{out_x: c[0], out_y: c[1], out_z: c[2], out_w: c[3], degenerate: 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.degenerate |-> res_o.out_w == UnitComp && res_o.out_x == '0 &&
                                   res_o.out_y == '0 && res_o.out_z == '0)
    else $error("degenerate beat is not the identity");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $signed(res_o.out_x) <= 16384 && $signed(res_o.out_x) >= -16384 &&
               $signed(res_o.out_w) <= 16384 && $signed(res_o.out_w) >= -16384)
    else $error("component outside unit range");

endmodule
